@@ rtl/qau_pkg.sv @@
// shared widths, codes, types and the saturation function of the quaternion unit
`default_nettype none
package qau_pkg;
    localparam int PART_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * PART_W;
    localparam int SQ_W   = 2 * PART_W + 1;
    localparam int QUO_W  = 2 * FRAC_W + 1;
    localparam int RT_W   = PART_W + 1;
    localparam int DREM_W = SQ_W + 1;
    localparam int RREM_W = RT_W + 2;
    localparam int STEPS  = (QUO_W > RT_W) ? QUO_W : RT_W;
    localparam int ACC_W  = (2 * PART_W + 2 > 2 * FRAC_W + 2) ? 2 * PART_W + 2
                                                              : 2 * FRAC_W + 2;

    typedef logic signed [PART_W-1:0] t_part;
    typedef logic        [PART_W-1:0] t_mag;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic        [SQ_W-1:0]   t_sq;
    typedef logic        [QUO_W-1:0]  t_quo;
    typedef logic        [RT_W-1:0]   t_root;

    typedef logic [3:0] t_mode;
    localparam t_mode MODE_CONJ  = 4'd0;
    localparam t_mode MODE_NORM2 = 4'd1;
    localparam t_mode MODE_NORM  = 4'd2;
    localparam t_mode MODE_QMUL  = 4'd3;
    localparam t_mode MODE_QCMUL = 4'd4;
    localparam t_mode MODE_CQMUL = 4'd5;
    localparam t_mode MODE_INV   = 4'd6;
    localparam t_mode MODE_QDIV  = 4'd7;
    localparam t_mode MODE_QCDIV = 4'd8;
    localparam t_mode MODE_CQDIV = 4'd9;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK  = 2'd0;
    localparam t_status ST_SAT = 2'd1;
    localparam t_status ST_DZ  = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE, OP_CONJ, OP_NORM2, OP_NORM, OP_QMUL, OP_QCMUL, OP_CQMUL,
        OP_INV, OP_QDIV, OP_QCDIV, OP_CQDIV
    } t_op;

    // classified word as it waits in the queue
    typedef struct packed {
        t_op         op;
        logic        src_a;
        logic        cplx;
        t_part [3:0] a;
        t_part [3:0] b;
    } t_item;

    // word leaving the divide and root pipeline
    typedef struct packed {
        logic        valid;
        t_item       item;
        t_sq         s;
        logic  [3:0] negr;
        t_quo  [3:0] quo;
        t_root       root;
    } t_rcp;

    typedef struct packed {
        t_part val;
        logic  ovf;
    } t_sat;

    function automatic t_sat sat_part(input t_acc v);
        t_sat r;
        t_acc hi;
        t_acc lo;
        hi = t_acc'({1'b0, {(PART_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            r.val = hi[PART_W-1:0];
            r.ovf = 1'b1;
        end else if (v < lo) begin
            r.val = lo[PART_W-1:0];
            r.ovf = 1'b1;
        end else begin
            r.val = v[PART_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

@@ rtl/qau_queue.sv @@
// two-entry queue between the front and the back of the quaternion unit
`default_nettype none
module qau_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire qau_pkg::t_item i_push_item,
    output logic               o_full,
    input  wire logic          i_pop,
    output qau_pkg::t_item     o_item,
    output logic               o_avail
);
    qau_pkg::t_item r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push, do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
endmodule
`default_nettype wire

@@ rtl/qau_front.sv @@
// front end: takes input words, classifies the operation and queues them
`default_nettype none
module qau_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire qau_pkg::t_mode        i_mode,
    input  wire qau_pkg::t_part [3:0]  i_a,
    input  wire qau_pkg::t_part [3:0]  i_b,
    input  wire logic                  i_pop,
    output qau_pkg::t_item             o_item,
    output logic                       o_avail
);
    qau_pkg::t_item n_item;
    logic           full;

    always_comb begin
        n_item.a     = i_a;
        n_item.b     = i_b;
        n_item.src_a = 1'b0;
        n_item.cplx  = 1'b0;
        unique case (i_mode)
            qau_pkg::MODE_CONJ: begin
                n_item.op    = qau_pkg::OP_CONJ;
                n_item.src_a = 1'b1;
            end
            qau_pkg::MODE_NORM2: begin
                n_item.op    = qau_pkg::OP_NORM2;
                n_item.src_a = 1'b1;
            end
            qau_pkg::MODE_NORM: begin
                n_item.op    = qau_pkg::OP_NORM;
                n_item.src_a = 1'b1;
            end
            qau_pkg::MODE_QMUL:  n_item.op = qau_pkg::OP_QMUL;
            qau_pkg::MODE_QCMUL: n_item.op = qau_pkg::OP_QCMUL;
            qau_pkg::MODE_CQMUL: n_item.op = qau_pkg::OP_CQMUL;
            qau_pkg::MODE_INV: begin
                n_item.op    = qau_pkg::OP_INV;
                n_item.src_a = 1'b1;
            end
            qau_pkg::MODE_QDIV:  n_item.op = qau_pkg::OP_QDIV;
            qau_pkg::MODE_QCDIV: begin
                n_item.op   = qau_pkg::OP_QCDIV;
                n_item.cplx = 1'b1;
            end
            qau_pkg::MODE_CQDIV: n_item.op = qau_pkg::OP_CQDIV;
            default:             n_item.op = qau_pkg::OP_NONE;
        endcase
    end

    assign o_ready = !full;

    qau_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_valid && !full),
        .i_push_item (n_item),
        .o_full      (full),
        .i_pop       (i_pop),
        .o_item      (o_item),
        .o_avail     (o_avail)
    );
endmodule
`default_nettype wire

@@ rtl/qau_recip.sv @@
// squared norm, then pipelined restoring divide and integer square root, one bit a stage
`default_nettype none
module qau_recip (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire logic           i_avail,
    input  wire qau_pkg::t_item i_item,
    output qau_pkg::t_rcp       o_rcp
);
    typedef struct packed {
        logic                                 valid;
        qau_pkg::t_item                       item;
        qau_pkg::t_sq                         s;
        logic [3:0]                           negr;
        logic [3:0][qau_pkg::DREM_W-1:0]      rem;
        qau_pkg::t_quo [3:0]                  quo;
        qau_pkg::t_root                       root;
        logic [qau_pkg::RREM_W-1:0]           rrem;
    } t_dv;

    // squaring stage
    logic                               r_sq_v;
    qau_pkg::t_item                     r_sq_item;
    qau_pkg::t_mag [3:0]                r_sq_mag, n_mag;
    logic [3:0][qau_pkg::PROD_W-1:0]    r_sq_sq, n_sq;
    logic [3:0]                         r_sq_negr, n_negr;
    qau_pkg::t_part [3:0]               src;

    t_dv r_pipe [qau_pkg::STEPS+1];
    t_dv n_pipe0;

    always_comb begin
        for (int p = 0; p < 4; p++) begin
            src[p] = i_item.src_a ? i_item.a[p] : i_item.b[p];
            if (i_item.cplx && p >= 2) begin
                src[p] = '0;
            end
            n_mag[p]  = src[p][qau_pkg::PART_W-1] ? qau_pkg::t_mag'(-src[p])
                                                   : qau_pkg::t_mag'(src[p]);
            n_sq[p]   = qau_pkg::PROD_W'(n_mag[p]) * qau_pkg::PROD_W'(n_mag[p]);
            n_negr[p] = (p == 0) ? src[p][qau_pkg::PART_W-1] : !src[p][qau_pkg::PART_W-1];
        end
    end

    always_comb begin
        n_pipe0       = '0;
        n_pipe0.valid = r_sq_v;
        n_pipe0.item  = r_sq_item;
        n_pipe0.negr  = r_sq_negr;
        n_pipe0.s     = qau_pkg::SQ_W'(r_sq_sq[0]) + qau_pkg::SQ_W'(r_sq_sq[1])
                      + qau_pkg::SQ_W'(r_sq_sq[2]) + qau_pkg::SQ_W'(r_sq_sq[3]);
        for (int p = 0; p < 4; p++) begin
            n_pipe0.rem[p] = qau_pkg::DREM_W'(r_sq_mag[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v          <= 1'b0;
            r_pipe[0].valid <= 1'b0;
        end else if (i_adv) begin
            r_sq_v    <= i_avail;
            r_sq_item <= i_item;
            r_sq_mag  <= n_mag;
            r_sq_sq   <= n_sq;
            r_sq_negr <= n_negr;
            r_pipe[0] <= n_pipe0;
        end
    end

    for (genvar k = 0; k < qau_pkg::STEPS; k++) begin : g_step
        localparam int RI = (k < qau_pkg::RT_W) ? 2 * (qau_pkg::RT_W - 1 - k) : 0;
        t_dv                              n_st;
        logic [2*qau_pkg::RT_W-1:0]       s_ext;
        logic [qau_pkg::RREM_W-1:0]       rsh, trial;
        logic [3:0][qau_pkg::DREM_W-1:0]  d_sub;
        logic [3:0]                       d_ge;

        always_comb begin
            n_st  = r_pipe[k];
            s_ext = {1'b0, r_pipe[k].s};
            rsh   = {r_pipe[k].rrem[qau_pkg::RREM_W-3:0], s_ext[RI +: 2]};
            trial = {r_pipe[k].root, 2'b01};
            for (int p = 0; p < 4; p++) begin
                d_ge[p]  = r_pipe[k].rem[p] >= {1'b0, r_pipe[k].s};
                d_sub[p] = d_ge[p] ? r_pipe[k].rem[p] - {1'b0, r_pipe[k].s}
                                   : r_pipe[k].rem[p];
            end
            if (k < qau_pkg::QUO_W) begin
                for (int p = 0; p < 4; p++) begin
                    n_st.rem[p] = {d_sub[p][qau_pkg::DREM_W-2:0], 1'b0};
                    n_st.quo[p] = {r_pipe[k].quo[p][qau_pkg::QUO_W-2:0], d_ge[p]};
                end
            end
            if (k < qau_pkg::RT_W) begin
                if (rsh >= trial) begin
                    n_st.rrem = rsh - trial;
                    n_st.root = {r_pipe[k].root[qau_pkg::RT_W-2:0], 1'b1};
                end else begin
                    n_st.rrem = rsh;
                    n_st.root = {r_pipe[k].root[qau_pkg::RT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pipe[k+1].valid <= 1'b0;
            end else if (i_adv) begin
                r_pipe[k+1] <= n_st;
            end
        end
    end

    always_comb begin
        o_rcp.valid = r_pipe[qau_pkg::STEPS].valid;
        o_rcp.item  = r_pipe[qau_pkg::STEPS].item;
        o_rcp.s     = r_pipe[qau_pkg::STEPS].s;
        o_rcp.negr  = r_pipe[qau_pkg::STEPS].negr;
        o_rcp.quo   = r_pipe[qau_pkg::STEPS].quo;
        o_rcp.root  = r_pipe[qau_pkg::STEPS].root;
    end
endmodule
`default_nettype wire

@@ rtl/qau_mulsat.sv @@
// inverse saturation, part products, result sums, final shift and saturation, output register
`default_nettype none
module qau_mulsat (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire qau_pkg::t_rcp        i_rcp,
    output logic                      o_adv,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output qau_pkg::t_part [3:0]      o_r,
    output qau_pkg::t_status          o_status
);
    // inverse stage
    logic                  r_m0_v;
    qau_pkg::t_item        r_m0_item;
    qau_pkg::t_sq          r_m0_s;
    qau_pkg::t_root        r_m0_root;
    qau_pkg::t_part [3:0]  r_m0_inv, n_inv;
    logic                  r_m0_iflag, r_m0_dz;
    qau_pkg::t_sat [3:0]   inv_sat;
    qau_pkg::t_acc [3:0]   inv_val;

    // product stage
    logic                  r_m1_v;
    qau_pkg::t_item        r_m1_item;
    qau_pkg::t_sq          r_m1_s;
    qau_pkg::t_root        r_m1_root;
    qau_pkg::t_part [3:0]  r_m1_inv;
    logic                  r_m1_iflag, r_m1_dz;
    qau_pkg::t_prod        r_m1_p [4][4];
    qau_pkg::t_prod        n_p [4][4];
    qau_pkg::t_part [3:0]  mx;

    // sum stage
    logic                  r_m2_v;
    qau_pkg::t_acc         r_m2_w [4];
    qau_pkg::t_acc         n_w [4];
    qau_pkg::t_acc         pe [4][4];
    logic                  r_m2_sh, n_sh;
    logic                  r_m2_flag, n_flag;
    logic                  r_m2_dz, n_dz;

    // output register
    logic                  r_out_v;
    qau_pkg::t_part [3:0]  r_out_r, n_r;
    qau_pkg::t_status      r_out_st, n_st;
    qau_pkg::t_sat [3:0]   fin_sat;
    qau_pkg::t_acc [3:0]   fin_val;

    assign o_adv = !r_out_v || i_ready;

    always_comb begin
        for (int p = 0; p < 4; p++) begin
            inv_val[p] = i_rcp.negr[p] ? -qau_pkg::t_acc'(i_rcp.quo[p])
                                       : qau_pkg::t_acc'(i_rcp.quo[p]);
            inv_sat[p] = qau_pkg::sat_part(inv_val[p]);
            n_inv[p]   = inv_sat[p].val;
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            mx[j] = r_m0_item.b[j];
            if (r_m0_item.op == qau_pkg::OP_QDIV || r_m0_item.op == qau_pkg::OP_QCDIV
                    || r_m0_item.op == qau_pkg::OP_CQDIV) begin
                mx[j] = r_m0_inv[j];
            end
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_p[i][j] = r_m0_item.a[i] * mx[j];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                pe[i][j] = qau_pkg::t_acc'(r_m1_p[i][j]);
            end
        end
        for (int k = 0; k < 4; k++) begin
            n_w[k] = '0;
        end
        n_sh   = 1'b0;
        n_flag = 1'b0;
        n_dz   = 1'b0;
        unique case (r_m1_item.op) inside
            qau_pkg::OP_CONJ: begin
                n_w[0] = qau_pkg::t_acc'(r_m1_item.a[0]);
                for (int k = 1; k < 4; k++) begin
                    n_w[k] = -qau_pkg::t_acc'(r_m1_item.a[k]);
                end
            end
            qau_pkg::OP_NORM2: begin
                n_w[0] = qau_pkg::t_acc'(r_m1_s);
                n_sh   = 1'b1;
            end
            qau_pkg::OP_NORM: n_w[0] = qau_pkg::t_acc'(r_m1_root);
            qau_pkg::OP_INV: begin
                for (int k = 0; k < 4; k++) begin
                    n_w[k] = qau_pkg::t_acc'(r_m1_inv[k]);
                end
                n_flag = r_m1_iflag;
                n_dz   = r_m1_dz;
            end
            qau_pkg::OP_QMUL, qau_pkg::OP_QDIV: begin
                n_w[0] = pe[0][0] - pe[1][1] - pe[2][2] - pe[3][3];
                n_w[1] = pe[0][1] + pe[1][0] + pe[2][3] - pe[3][2];
                n_w[2] = pe[0][2] + pe[2][0] - pe[1][3] + pe[3][1];
                n_w[3] = pe[0][3] + pe[3][0] + pe[1][2] - pe[2][1];
                n_sh   = 1'b1;
                n_flag = (r_m1_item.op == qau_pkg::OP_QDIV) && r_m1_iflag;
                n_dz   = (r_m1_item.op == qau_pkg::OP_QDIV) && r_m1_dz;
            end
            qau_pkg::OP_QCMUL, qau_pkg::OP_QCDIV: begin
                n_w[0] = pe[0][0] - pe[1][1];
                n_w[1] = pe[0][1] + pe[1][0];
                n_w[2] = pe[2][0] + pe[3][1];
                n_w[3] = pe[3][0] - pe[2][1];
                n_sh   = 1'b1;
                n_flag = (r_m1_item.op == qau_pkg::OP_QCDIV) && r_m1_iflag;
                n_dz   = (r_m1_item.op == qau_pkg::OP_QCDIV) && r_m1_dz;
            end
            qau_pkg::OP_CQMUL, qau_pkg::OP_CQDIV: begin
                n_w[0] = pe[0][0] - pe[1][1];
                n_w[1] = pe[0][1] + pe[1][0];
                n_w[2] = pe[0][2] - pe[1][3];
                n_w[3] = pe[0][3] + pe[1][2];
                n_sh   = 1'b1;
                n_flag = (r_m1_item.op == qau_pkg::OP_CQDIV) && r_m1_iflag;
                n_dz   = (r_m1_item.op == qau_pkg::OP_CQDIV) && r_m1_dz;
            end
            default: n_sh = 1'b0;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            fin_val[k] = r_m2_sh ? (r_m2_w[k] >>> qau_pkg::FRAC_W) : r_m2_w[k];
            fin_sat[k] = qau_pkg::sat_part(fin_val[k]);
            n_r[k]     = r_m2_dz ? '0 : fin_sat[k].val;
        end
        if (r_m2_dz) begin
            n_st = qau_pkg::ST_DZ;
        end else if (r_m2_flag || fin_sat[0].ovf || fin_sat[1].ovf
                     || fin_sat[2].ovf || fin_sat[3].ovf) begin
            n_st = qau_pkg::ST_SAT;
        end else begin
            n_st = qau_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0_v  <= 1'b0;
            r_m1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (o_adv) begin
            r_m0_v     <= i_rcp.valid;
            r_m0_item  <= i_rcp.item;
            r_m0_s     <= i_rcp.s;
            r_m0_root  <= i_rcp.root;
            r_m0_inv   <= n_inv;
            r_m0_iflag <= inv_sat[0].ovf | inv_sat[1].ovf | inv_sat[2].ovf | inv_sat[3].ovf;
            r_m0_dz    <= (i_rcp.s == '0);

            r_m1_v     <= r_m0_v;
            r_m1_item  <= r_m0_item;
            r_m1_s     <= r_m0_s;
            r_m1_root  <= r_m0_root;
            r_m1_inv   <= r_m0_inv;
            r_m1_iflag <= r_m0_iflag;
            r_m1_dz    <= r_m0_dz;
            r_m1_p     <= n_p;

            r_m2_v     <= r_m1_v;
            r_m2_w     <= n_w;
            r_m2_sh    <= n_sh;
            r_m2_flag  <= n_flag;
            r_m2_dz    <= n_dz;

            r_out_v    <= r_m2_v;
            r_out_r    <= n_r;
            r_out_st   <= n_st;
        end
    end

    assign o_valid  = r_out_v;
    assign o_r      = r_out_r;
    assign o_status = r_out_st;
endmodule
`default_nettype wire

@@ rtl/quaternion_arith_unit.sv @@
// top level of the quaternion multiply and divide unit
`default_nettype none
// Takes one word per clock and gives one result word per clock for a steady stream while the
// output is not stalled: every operation, cheap or not, runs down the same pipeline, so results
// leave in the order taken. The pipeline depth is set by the restoring divider and the integer
// square root, which each resolve one result bit per pipeline stage (2*FRAC_W+1 quotient bits
// and PART_W+1 root bits for Q16.16 parts), plus the queue, two squaring stages and four
// multiply and output stages. A two-entry queue parts the input from the pipeline; a stalled
// output holds the whole back end. Status 2 (zero divisor norm) wins over status 1
// (saturation).
module quaternion_arith_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [3:0]           i_mode,
    input  wire qau_pkg::t_part       i_a_0,
    input  wire qau_pkg::t_part       i_a_1,
    input  wire qau_pkg::t_part       i_a_2,
    input  wire qau_pkg::t_part       i_a_3,
    input  wire qau_pkg::t_part       i_b_0,
    input  wire qau_pkg::t_part       i_b_1,
    input  wire qau_pkg::t_part       i_b_2,
    input  wire qau_pkg::t_part       i_b_3,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output qau_pkg::t_part            o_r_0,
    output qau_pkg::t_part            o_r_1,
    output qau_pkg::t_part            o_r_2,
    output qau_pkg::t_part            o_r_3,
    output qau_pkg::t_status          o_status
);
    qau_pkg::t_item       q_item;
    logic                 q_avail;
    logic                 adv;
    qau_pkg::t_rcp        rcp;
    qau_pkg::t_part [3:0] res;

    qau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mode  (i_mode),
        .i_a     ({i_a_3, i_a_2, i_a_1, i_a_0}),
        .i_b     ({i_b_3, i_b_2, i_b_1, i_b_0}),
        .i_pop   (adv),
        .o_item  (q_item),
        .o_avail (q_avail)
    );

    qau_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_avail (q_avail),
        .i_item  (q_item),
        .o_rcp   (rcp)
    );

    qau_mulsat u_mulsat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rcp    (rcp),
        .o_adv    (adv),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_r      (res),
        .o_status (o_status)
    );

    assign o_r_0 = res[0];
    assign o_r_1 = res[1];
    assign o_r_2 = res[2];
    assign o_r_3 = res[3];
endmodule
`default_nettype wire

@@ rtl/qau_checker.sv @@
// port-level checks on the quaternion unit, bound to the top level
`default_nettype none
module qau_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_valid,
    input wire logic                 o_ready,
    input wire logic                 o_valid,
    input wire logic                 i_ready,
    input wire qau_pkg::t_part       o_r_0,
    input wire qau_pkg::t_part       o_r_1,
    input wire qau_pkg::t_part       o_r_2,
    input wire qau_pkg::t_part       o_r_3,
    input wire qau_pkg::t_status     o_status
);
    // a held result word keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_r_0)
            && $stable(o_r_1) && $stable(o_r_2) && $stable(o_r_3))
        else $error("result word changed while stalled");

    // zero divisor norm gives all parts zero
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == qau_pkg::ST_DZ |-> o_r_0 == '0 && o_r_1 == '0
            && o_r_2 == '0 && o_r_3 == '0)
        else $error("zero norm result with nonzero parts");

    // reset empties the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word present after reset");

    // reset leaves the queue empty and open
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready after reset");

    // with no word offered the queue cannot fill up
    a_ready_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && !i_valid |=> o_ready)
        else $error("input closed with no word taken");
endmodule

bind quaternion_arith_unit qau_checker u_qau_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_r_0    (o_r_0),
    .o_r_1    (o_r_1),
    .o_r_2    (o_r_2),
    .o_r_3    (o_r_3),
    .o_status (o_status)
);
`default_nettype wire
